// File: sv/hsl_saturation_replace_unit_defines.svh
// Assertion macros shared by the checker of the saturation replace unit.
`ifndef HSL_SATURATION_REPLACE_UNIT_DEFINES_SVH
`define HSL_SATURATION_REPLACE_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define HSR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define HSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define HSR_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hsr_pkg.sv
// Shared types and constants of the saturation replace unit.
`timescale 1ns / 1ps
package hsr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    // Quotient bits of the old saturation divider.
    localparam int SAT_QW = 9;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [8:0] s;
        logic [7:0] span;
        logic [7:0] n;
        t_sector    sector;
        logic       neg;
        logic       hue_zero;
        logic       sat_zero;
    } t_side;

endpackage

// File: sv/hsl_saturation_replace_unit.sv
// An accepted input beat passes the front stage, the hue divider stages and the back stages to its output beat.
// Throughput: one pixel per cycle; the hue divider retires one quotient bit per stage.
// The whole pipeline advances together unless the output beat is held by i_stall.
// Reset (synchronous, active low) clears only the valid bits; payload is not reset.
// No configuration and no stored state survive between pixels.
`timescale 1ns / 1ps
module hsl_saturation_replace_unit import hsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_blue_in,
    input  logic [7:0] i_new_saturation,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out,
    output logic [7:0] o_old_saturation
);

    // Hue quotient needs FRAC_BITS + 1 bits, one divider stage per bit.
    localparam int HUE_QW = FRAC_BITS + 1;
    localparam int LAT    = HUE_QW + 5;

    // The pipeline only freezes when a finished beat is waiting downstream,
    // so bubbles inside the pipe never block a new pixel.
    logic en;
    logic [LAT-1:0] r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Front stage: extremes, span, hue section and the divider operands.
    t_side                 front_side;
    logic [FRAC_BITS+8:0]  hue_num;
    logic [8:0]            hue_den, sat_den;
    logic [16:0]           sat_num;

    hsr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_red     (i_red_in),
        .i_green   (i_green_in),
        .i_blue    (i_blue_in),
        .i_sat     (i_new_saturation),
        .o_side    (front_side),
        .o_hue_num (hue_num),
        .o_hue_den (hue_den),
        .o_sat_num (sat_num),
        .o_sat_den (sat_den)
    );

    // Hue fraction: round(|num| * 2^F / d), done as floor((2*|num|*2^F + d) / 2d).
    logic [FRAC_BITS:0] hue_q;

    hsr_div #(.NW(FRAC_BITS + 9), .DW(9), .QW(HUE_QW)) u_hue_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (hue_num),
        .i_den (hue_den),
        .o_quo (hue_q)
    );

    // Old saturation: floor((510*d + span) / (2*span)), a shorter divider that
    // is then delayed to line up with the hue quotient.
    logic [SAT_QW-1:0] sat_q_early, sat_q;

    hsr_div #(.NW(17), .DW(9), .QW(SAT_QW)) u_sat_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (sat_num),
        .i_den (sat_den),
        .o_quo (sat_q_early)
    );

    hsr_delay #(.W(SAT_QW), .DEPTH(HUE_QW - SAT_QW)) u_sat_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (sat_q_early),
        .o_q   (sat_q)
    );

    // Sideband fields ride alongside the hue divider.
    logic [$bits(t_side)-1:0] side_bits;
    t_side                    back_side;

    hsr_delay #(.W($bits(t_side)), .DEPTH(HUE_QW)) u_side_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (front_side),
        .o_q   (side_bits)
    );

    assign back_side = t_side'(side_bits);

    // Back end: weights, products, rounding and the output register.
    hsr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_side    (back_side),
        .i_hue_q   (hue_q),
        .i_sat_q   (sat_q),
        .o_red     (o_red_out),
        .o_green   (o_green_out),
        .o_blue    (o_blue_out),
        .o_old_sat (o_old_saturation)
    );

endmodule

// File: sv/hsr_front.sv
// First stage: max, min, lightness span, hue section and divider operands.
`timescale 1ns / 1ps
module hsr_front import hsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    input  logic [7:0]           i_sat,
    output t_side                o_side,
    output logic [FRAC_BITS+8:0] o_hue_num,
    output logic [8:0]           o_hue_den,
    output logic [16:0]          o_sat_num,
    output logic [8:0]           o_sat_den
);

    logic [7:0]  mx, mn, d, span, mag;
    logic [8:0]  s, diff;
    t_sector     sector;
    logic        neg;
    logic [16:0] sat_num;
    t_side       n_side;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        d = mx - mn;
        s = {1'b0, mx} + {1'b0, mn};
        span = (s <= 9'd255) ? s[7:0] : 8'(9'd510 - s);

        // Red wins ties, then green.
        if (mx == i_red) begin
            sector = SEC_RED;
            diff = {1'b0, i_green} - {1'b0, i_blue};
        end else if (mx == i_green) begin
            sector = SEC_GREEN;
            diff = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            sector = SEC_BLUE;
            diff = {1'b0, i_red} - {1'b0, i_green};
        end
        neg = diff[8];
        mag = neg ? 8'(-diff) : diff[7:0];

        sat_num = 17'(d) * 17'd510 + 17'(span);

        n_side.s = s;
        n_side.span = span;
        n_side.n = i_sat;
        n_side.sector = sector;
        n_side.neg = neg;
        n_side.hue_zero = (d == 8'd0);
        n_side.sat_zero = (d == 8'd0) || (span == 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= n_side;
            o_hue_num <= {mag, 1'b0, {(FRAC_BITS - 8){1'b0}}, d};
            o_hue_den <= {d, 1'b0};
            o_sat_num <= sat_num;
            o_sat_den <= {span, 1'b0};
        end
    end

endmodule

// File: sv/hsr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module hsr_div #(
    parameter int NW = 25,
    parameter int DW = 9,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int CW = ((NW > DW + QW - 1) ? NW : DW + QW - 1) + 1;

    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [NW-1:0] rem_in, n_rem;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in, n_quo;
            logic [CW-1:0] shifted;

            if (k == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign den_in = r_den[k-1];
                assign quo_in = r_quo[k-1];
            end

            always_comb begin
                shifted = CW'(den_in) << (QW - 1 - k);
                n_rem = rem_in;
                n_quo = quo_in;
                if (CW'(rem_in) >= shifted) begin
                    n_rem = NW'(CW'(rem_in) - shifted);
                    n_quo[QW-1-k] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                    r_quo[k] <= n_quo;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QW-1];

endmodule

// File: sv/hsr_delay.sv
// Payload delay line that advances with the pipeline enable.
`timescale 1ns / 1ps
module hsr_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

// File: sv/hsr_back.sv
// Back stages: hue weights, chroma products, rounding and the divide by 510.
`timescale 1ns / 1ps
module hsr_back import hsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_side                i_side,
    input  logic [FRAC_BITS:0]   i_hue_q,
    input  logic [SAT_QW-1:0]    i_sat_q,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [7:0]           o_old_sat
);

    localparam int FB = FRAC_BITS;
    localparam int WW = FB + 2;
    localparam int PW = FB + 19;
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    // Stage one: hue times six and per-channel weights.
    logic [2:0]             k;
    logic [FB+2:0]          h6, wx_wide;
    logic [FB:0]            f, hue_off, t;
    logic signed [WW-1:0]   wx, wc, wz;
    logic signed [WW-1:0]   n_w [3];

    logic signed [WW-1:0]   r1_w [3];
    logic [15:0]            r1_dn;
    logic [8:0]             r1_s;
    logic [7:0]             r1_sat;

    always_comb begin
        case (i_side.sector)
            SEC_RED:   k = i_side.neg ? 3'd6 : 3'd0;
            SEC_GREEN: k = 3'd2;
            SEC_BLUE:  k = 3'd4;
            default:   k = 3'd0;
        endcase
        if (i_side.hue_zero) begin
            h6 = '0;
        end else if (i_side.neg) begin
            h6 = {k, {FB{1'b0}}} - {2'b00, i_hue_q};
        end else begin
            h6 = {k, {FB{1'b0}}} + {2'b00, i_hue_q};
        end
        f = h6[FB:0];
        hue_off = (f >= ONE) ? f - ONE : ONE - f;
        t = ONE - hue_off;
        wx_wide = {1'b0, t, 1'b0} - {2'b00, ONE};
        wx = signed'(wx_wide[WW-1:0]);
        wc = signed'({1'b0, ONE});
        wz = -wc;
        case (h6[FB+2:FB])
            3'd0: begin n_w[0] = wc; n_w[1] = wx; n_w[2] = wz; end
            3'd1: begin n_w[0] = wx; n_w[1] = wc; n_w[2] = wz; end
            3'd2: begin n_w[0] = wz; n_w[1] = wc; n_w[2] = wx; end
            3'd3: begin n_w[0] = wz; n_w[1] = wx; n_w[2] = wc; end
            3'd4: begin n_w[0] = wx; n_w[1] = wz; n_w[2] = wc; end
            default: begin n_w[0] = wc; n_w[1] = wz; n_w[2] = wx; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_w <= n_w;
            r1_dn <= 16'(i_side.span) * 16'(i_side.n);
            r1_s <= i_side.s;
            r1_sat <= i_side.sat_zero ? 8'd0 : i_sat_q[7:0];
        end
    end

    // Stage two: the chroma products.
    logic signed [PW-1:0] r2_p [3];
    logic [8:0]           r2_s;
    logic [7:0]           r2_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r2_p[c] <= $signed({1'b0, r1_dn}) * r1_w[c];
            end
            r2_s <= r1_s;
            r2_sat <= r1_sat;
        end
    end

    // Stage three: add the lightness term and the rounding half, drop fraction.
    logic [16:0]          base255;
    logic signed [PW-1:0] num [3];
    logic [PW-1:0]        xs [3];
    logic [PW-FB-2:0]     n_x [3];
    logic [PW-FB-2:0]     r3_x [3];
    logic [7:0]           r3_sat;

    always_comb begin
        base255 = 17'(r2_s) * 17'd255;
        for (int c = 0; c < 3; c++) begin
            num[c] = $signed({2'b00, base255, {FB{1'b0}}}) + r2_p[c];
            xs[c] = PW'(num[c]) + {{(PW - FB - 8){1'b0}}, 8'd255, {FB{1'b0}}};
            n_x[c] = num[c][PW-1] ? '0 : xs[c][PW-1:FB+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_x <= n_x;
            r3_sat <= r2_sat;
        end
    end

    // Stage four: divide by 255 through a reciprocal with one correction, clamp.
    logic [24:0] prod [3];
    logic [7:0]  q0 [3];
    logic [15:0] rem [3];
    logic [7:0]  n_ch [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = 25'(r3_x[c][15:0]) * 25'd257;
            q0[c] = prod[c][23:16];
            rem[c] = r3_x[c][15:0] - 16'(q0[c]) * 16'd255;
            if (r3_x[c] >= (PW - FB - 1)'(65280)) begin
                n_ch[c] = 8'hFF;
            end else begin
                n_ch[c] = q0[c] + 8'(rem[c] >= 16'd255);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_red <= n_ch[0];
            o_green <= n_ch[1];
            o_blue <= n_ch[2];
            o_old_sat <= r3_sat;
        end
    end

endmodule

// File: sv/hsr_checker.sv
// Port-level checker for the saturation replace unit, bound to the top level.
`timescale 1ns / 1ps
`include "hsl_saturation_replace_unit_defines.svh"
module hsr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_red_out,
    input logic [7:0] o_green_out,
    input logic [7:0] o_blue_out,
    input logic [7:0] o_old_saturation
);

    `HSR_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_valid, "valid after reset")
    `HSR_ASSERT_SAME(a_stall_only_blocked, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a blocked output beat")
    `HSR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out) && $stable(o_old_saturation), "held output beat changed")

endmodule

bind hsl_saturation_replace_unit hsr_checker u_hsr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_red_out        (o_red_out),
    .o_green_out      (o_green_out),
    .o_blue_out       (o_blue_out),
    .o_old_saturation (o_old_saturation)
);

// File: bench/tb.sv
// Self-checking bench for the HSL saturation replace unit: directed table, then random pixels.
`timescale 1ns / 1ps
module tb;
    import hsr_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = FB + 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 1750;
    localparam int N_DIRECTED = 16;

    // One pixel in, and the pixel rebuilt plus the old saturation out.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] sat;
    } t_pixel;

    // A row of the directed table; a row with known set carries its answer.
    typedef struct packed {
        t_pixel pix;
        logic   known;
        t_pixel answer;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_red_in;
    logic [7:0] i_green_in;
    logic [7:0] i_blue_in;
    logic [7:0] i_new_saturation;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_red_out;
    logic [7:0] o_green_out;
    logic [7:0] o_blue_out;
    logic [7:0] o_old_saturation;

    t_pixel pending_pixels[$];
    int     error_count;
    int     idle_cycles;
    bit     no_idle;
    bit     timed_out;
    t_row   directed[N_DIRECTED];

    hsl_saturation_replace_unit u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Rounded channel from the lightness sum, the span times the new saturation,
    // and the signed weight of this channel.
    function automatic logic [7:0] rebuild_channel(longint sum_lm, longint dn, longint w);
        longint num;
        longint den;
        longint v;
        num = 255 * sum_lm * (longint'(1) << FB) + dn * w;
        den = longint'(510) << FB;
        if (num < 0) return 8'd0;
        v = (2 * num + den) / (2 * den);
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic t_pixel replace_saturation(t_pixel p);
        longint r, g, b, n, one, mx, mn, d, s, span, h6, f, hue_off, wx, dn;
        longint num, base, mag, q, osat;
        longint wr, wg, wb;
        t_pixel res;
        r = longint'(p.red); g = longint'(p.green); b = longint'(p.blue);
        n = longint'(p.sat);
        one = longint'(1) << FB;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        s = mx + mn;
        span = (s <= 255) ? s : 510 - s;
        osat = 0;
        if (d != 0 && span != 0) osat = (510 * d + span) / (2 * span);
        if (osat > 255) osat = 255;
        // Hue times six; red wins ties, then green. A grey pixel sits at hue 0.
        h6 = 0;
        if (d != 0) begin
            if (mx == r) begin
                num = g - b; base = 0;
            end else if (mx == g) begin
                num = b - r; base = 2 * one;
            end else begin
                num = r - g; base = 4 * one;
            end
            mag = (num < 0) ? -num : num;
            q = ((mag << FB) * 2 + d) / (2 * d);
            if (num < 0) h6 = ((base == 0) ? 6 * one : base) - q;
            else h6 = base + q;
        end
        f = h6 & (2 * one - 1);
        hue_off = (f >= one) ? f - one : one - f;
        wx = 2 * (one - hue_off) - one;
        case (h6 >> FB)
            0: begin wr = one;  wg = wx;   wb = -one; end
            1: begin wr = wx;   wg = one;  wb = -one; end
            2: begin wr = -one; wg = one;  wb = wx;   end
            3: begin wr = -one; wg = wx;   wb = one;  end
            4: begin wr = wx;   wg = -one; wb = one;  end
            default: begin wr = one; wg = -one; wb = wx; end
        endcase
        dn = span * n;
        res.red = rebuild_channel(s, dn, wr);
        res.green = rebuild_channel(s, dn, wg);
        res.blue = rebuild_channel(s, dn, wb);
        res.sat = osat[7:0];
        return res;
    endfunction

    // Drive one beat and hold it until accepted; random gaps before it.
    // Valid stays high after the beat so that the next one can follow at once.
    task automatic send_pixel(t_pixel p);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_red_in <= p.red;
        i_green_in <= p.green;
        i_blue_in <= p.blue;
        i_new_saturation <= p.sat;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_pixels.push_back(replace_saturation(p));
        @(negedge i_clk);
    endtask

    // Output side: random stall bursts, and a check of each accepted beat.
    initial begin
        int burst;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 12);
                i_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("output beat with no pixel outstanding");
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_red_out !== want.red) begin
                    $error("red_out expected %0d got %0d", want.red, o_red_out);
                    error_count++;
                end
                if (o_green_out !== want.green) begin
                    $error("green_out expected %0d got %0d", want.green, o_green_out);
                    error_count++;
                end
                if (o_blue_out !== want.blue) begin
                    $error("blue_out expected %0d got %0d", want.blue, o_blue_out);
                    error_count++;
                end
                if (o_old_saturation !== want.sat) begin
                    $error("old_saturation expected %0d got %0d", want.sat, o_old_saturation);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("hsl_saturation_replace_unit verification failed");
            $finish;
        end
    end

    initial begin
        t_pixel p;
        t_pixel got;
        int k;
        error_count = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        timed_out = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_red_in = 8'd0;
        i_green_in = 8'd0;
        i_blue_in = 8'd0;
        i_new_saturation = 8'd0;

        // Black, white and greys: span or chroma is zero, so the result is trivial.
        directed[0] = '{pix: '{8'd0, 8'd0, 8'd0, 8'd255}, known: 1'b1,
                        answer: '{8'd0, 8'd0, 8'd0, 8'd0}};
        directed[1] = '{pix: '{8'd255, 8'd255, 8'd255, 8'd255}, known: 1'b1,
                        answer: '{8'd255, 8'd255, 8'd255, 8'd0}};
        directed[2] = '{pix: '{8'd128, 8'd128, 8'd128, 8'd0}, known: 1'b1,
                        answer: '{8'd128, 8'd128, 8'd128, 8'd0}};
        // Pure primaries at full saturation come back unchanged.
        directed[3] = '{pix: '{8'd255, 8'd0, 8'd0, 8'd255}, known: 1'b1,
                        answer: '{8'd255, 8'd0, 8'd0, 8'd255}};
        directed[4] = '{pix: '{8'd0, 8'd255, 8'd0, 8'd255}, known: 1'b1,
                        answer: '{8'd0, 8'd255, 8'd0, 8'd255}};
        directed[5] = '{pix: '{8'd0, 8'd0, 8'd255, 8'd255}, known: 1'b1,
                        answer: '{8'd0, 8'd0, 8'd255, 8'd255}};
        // Full desaturation of a primary gives mid grey.
        directed[6] = '{pix: '{8'd255, 8'd0, 8'd0, 8'd0}, known: 1'b1,
                        answer: '{8'd128, 8'd128, 8'd128, 8'd255}};
        // A grey pixel with new saturation lands in the red section.
        directed[7] = '{pix: '{8'd100, 8'd100, 8'd100, 8'd255}, known: 1'b0, answer: '0};
        // Hue sections one to five, ties between maxima, and a negative red-section hue.
        directed[8] = '{pix: '{8'd255, 8'd255, 8'd0, 8'd128}, known: 1'b0, answer: '0};
        directed[9] = '{pix: '{8'd0, 8'd255, 8'd255, 8'd200}, known: 1'b0, answer: '0};
        directed[10] = '{pix: '{8'd255, 8'd0, 8'd255, 8'd77}, known: 1'b0, answer: '0};
        directed[11] = '{pix: '{8'd200, 8'd10, 8'd90, 8'd255}, known: 1'b0, answer: '0};
        directed[12] = '{pix: '{8'd10, 8'd200, 8'd90, 8'd1}, known: 1'b0, answer: '0};
        directed[13] = '{pix: '{8'd90, 8'd10, 8'd200, 8'd254}, known: 1'b0, answer: '0};
        // Near-white and near-black, where the span is small.
        directed[14] = '{pix: '{8'd254, 8'd255, 8'd253, 8'd255}, known: 1'b0, answer: '0};
        directed[15] = '{pix: '{8'd1, 8'd0, 8'd2, 8'd170}, known: 1'b0, answer: '0};

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < N_DIRECTED; k++) begin
            if (directed[k].known) begin
                got = replace_saturation(directed[k].pix);
                if (got !== directed[k].answer) begin
                    $error("table row %0d predictor disagrees with typed answer", k);
                    error_count++;
                end
            end
            send_pixel(directed[k].pix);
        end

        for (k = 0; k < N_RANDOM; k++) begin
            // Hold off once until every outstanding pixel has come back.
            if (k == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (pending_pixels.size() != 0) @(negedge i_clk);
            end
            if (k == N_RANDOM - 200) no_idle = 1'b1;
            p.red = 8'($urandom_range(0, 255));
            p.green = 8'($urandom_range(0, 255));
            p.blue = 8'($urandom_range(0, 255));
            p.sat = 8'($urandom_range(0, 255));
            // Some pixels are greys, carry two equal channels, or have red or the new saturation pinned at an extreme.
            case ($urandom_range(0, 9))
                0: begin p.green = p.red; p.blue = p.red; end
                1: p.red = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                2: p.green = p.blue;
                3: p.sat = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                default: ;
            endcase
            send_pixel(p);
        end

        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);

        if (error_count == 0) begin
            $display("hsl_saturation_replace_unit verification clean");
        end else begin
            $display("hsl_saturation_replace_unit verification failed");
        end
        $finish;
    end
endmodule
